@@ hw/rtl/fpts_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpts_pkg
// Types, constants and the control store of the fixed-priority task
// scheduler.
// ----------------------------------------------------------------------------
package fpts_pkg;

   localparam int TASK_COUNT = 5;
   localparam int TASK_BITS  = (TASK_COUNT > 1) ? $clog2(TASK_COUNT) : 1;
   localparam int TID_BITS   = 3;
   localparam int ADDR_BITS  = 16;
   localparam int PRIO_BITS  = 8;
   localparam int SETUP_REGS = 4;
   localparam int CSR_BITS   = 25;
   localparam int CSR_IDX_BITS = 3;
   localparam int STEP_BITS  = 4;

   typedef logic [TASK_BITS-1:0] task_idx_type;
   typedef logic [STEP_BITS-1:0] step_type;

   // register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_TASK1_SETUP = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_TASK2_SETUP = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_TASK3_SETUP = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_TASK4_SETUP = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_ROOT_ENTRY  = 3'd4;

   typedef enum logic [1:0] {
      MODE_START     = 2'd0,
      MODE_ACTIVATE  = 2'd1,
      MODE_CHAIN     = 2'd2,
      MODE_TERMINATE = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      TS_SUSPENDED = 2'd0,
      TS_READY     = 2'd1,
      TS_RUNNING   = 2'd2
   } task_state_type;

   typedef struct packed {
      mode_type            mode;
      logic [TID_BITS-1:0] task_id;
      logic [ADDR_BITS-1:0] resume_address;
   } req_type;

   typedef struct packed {
      logic [TID_BITS-1:0]  run_task;
      logic [ADDR_BITS-1:0] jump_address;
   } rsp_type;

   typedef struct packed {
      logic                  autostart;
      logic [PRIO_BITS-1:0]  prio;
      logic [ADDR_BITS-1:0]  start_addr;
   } task_setup_type;

   // control word fields
   typedef enum logic [1:0] {SEL_ZERO, SEL_CUR, SEL_TID, SEL_SCAN} sel_type;
   typedef enum logic [1:0] {STW_NONE, STW_READY, STW_SUSP, STW_RUN} st_wr_type;
   typedef enum logic [2:0] {
      C_ALWAYS, C_SUSP, C_SUSP_AUTO, C_NOT_ROOT, C_TID_OK, C_TID_OK_SUSP
   } cond_type;
   typedef enum logic [1:0] {RPW_NONE, RPW_RET, RPW_START} rp_wr_type;
   typedef enum logic [2:0] {
      SC_NONE, SC_INIT_ZERO, SC_INIT_ONE, SC_INC, SC_PICK
   } scan_op_type;
   typedef enum logic [1:0] {CU_NONE, CU_TID, CU_PICK} cur_op_type;
   typedef enum logic [1:0] {J_NEXT, J_GO, J_LOOP, J_TID_BAD} jump_type;

   typedef struct packed {
      sel_type     sel;
      st_wr_type   st_wr;
      cond_type    st_cond;
      rp_wr_type   rp_wr;
      cond_type    rp_cond;
      scan_op_type scan_op;
      cur_op_type  cur_op;
      jump_type    jump;
      step_type    target;
      logic        emit;
   } uword_type;

   typedef struct packed {
      logic scan_last;
      logic tid_bad;
   } dp_status_type;

   // program steps
   localparam step_type STEP_START     = 4'd0;
   localparam step_type STEP_AUTO      = 4'd1;
   localparam step_type STEP_ACT_SAVE  = 4'd2;
   localparam step_type STEP_ACT_WAKE  = 4'd3;
   localparam step_type STEP_CHN_LEAVE = 4'd4;
   localparam step_type STEP_CHN_ENTER = 4'd5;
   localparam step_type STEP_TERM      = 4'd6;
   localparam step_type STEP_SCHED     = 4'd7;
   localparam step_type STEP_SCAN      = 4'd8;
   localparam step_type STEP_PICK      = 4'd9;
   localparam step_type STEP_OUT       = 4'd10;

   localparam uword_type UWORD_NOP = '{
      sel: SEL_ZERO, st_wr: STW_NONE, st_cond: C_ALWAYS, rp_wr: RPW_NONE,
      rp_cond: C_ALWAYS, scan_op: SC_NONE, cur_op: CU_NONE, jump: J_NEXT,
      target: STEP_START, emit: 1'b0
   };

   function automatic step_type entry_of(input mode_type mode);
      step_type s;
      case (mode)
         MODE_START:     s = STEP_START;
         MODE_ACTIVATE:  s = STEP_ACT_SAVE;
         MODE_CHAIN:     s = STEP_CHN_LEAVE;
         MODE_TERMINATE: s = STEP_TERM;
         default:        s = STEP_TERM;
      endcase
      return s;
   endfunction

   function automatic uword_type ucode_rom(input step_type step);
      uword_type w;
      w = UWORD_NOP;
      case (step)
         STEP_START: begin
            w.sel     = SEL_ZERO;
            w.st_wr   = STW_READY;
            w.rp_wr   = RPW_START;
            w.scan_op = SC_INIT_ONE;
         end
         STEP_AUTO: begin
            w.sel     = SEL_SCAN;
            w.st_wr   = STW_READY;
            w.st_cond = C_SUSP_AUTO;
            w.rp_wr   = RPW_START;
            w.rp_cond = C_SUSP_AUTO;
            w.scan_op = SC_INC;
            w.jump    = J_LOOP;
            w.target  = STEP_SCHED;
         end
         STEP_ACT_SAVE: begin
            w.sel     = SEL_CUR;
            w.rp_wr   = RPW_RET;
         end
         STEP_ACT_WAKE: begin
            w.sel     = SEL_TID;
            w.st_wr   = STW_READY;
            w.st_cond = C_TID_OK_SUSP;
            w.rp_wr   = RPW_START;
            w.rp_cond = C_TID_OK_SUSP;
            w.jump    = J_GO;
            w.target  = STEP_SCHED;
         end
         STEP_CHN_LEAVE: begin
            w.sel     = SEL_CUR;
            w.st_wr   = STW_SUSP;
            w.st_cond = C_TID_OK;
            w.jump    = J_TID_BAD;
            w.target  = STEP_OUT;
         end
         STEP_CHN_ENTER: begin
            w.sel     = SEL_TID;
            w.st_wr   = STW_RUN;
            w.rp_wr   = RPW_START;
            w.rp_cond = C_SUSP;
            w.cur_op  = CU_TID;
            w.jump    = J_GO;
            w.target  = STEP_OUT;
         end
         STEP_TERM: begin
            w.sel     = SEL_CUR;
            w.st_wr   = STW_SUSP;
            w.st_cond = C_NOT_ROOT;
            w.jump    = J_GO;
            w.target  = STEP_SCHED;
         end
         STEP_SCHED: begin
            w.scan_op = SC_INIT_ZERO;
         end
         STEP_SCAN: begin
            w.sel     = SEL_SCAN;
            w.scan_op = SC_PICK;
            w.jump    = J_LOOP;
            w.target  = STEP_PICK;
         end
         STEP_PICK: begin
            w.cur_op  = CU_PICK;
         end
         STEP_OUT: begin
            w.sel     = SEL_CUR;
            w.emit    = 1'b1;
         end
         default: begin
            w.sel     = SEL_CUR;
            w.emit    = 1'b1;
         end
      endcase
      return w;
   endfunction

endpackage

@@ hw/rtl/fpts_csr.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpts_csr
// Setup registers and the per-task view of start address, priority and
// autostart.
// ----------------------------------------------------------------------------
module fpts_csr (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_wr_en,
   input  logic [fpts_pkg::CSR_IDX_BITS-1:0]     csr_index,
   input  logic [fpts_pkg::CSR_BITS-1:0]         csr_wr_data,
   output fpts_pkg::task_setup_type              setups [fpts_pkg::TASK_COUNT]
);
   import fpts_pkg::*;

   logic [CSR_BITS-1:0]  setup_ff [SETUP_REGS];
   logic [ADDR_BITS-1:0] root_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SETUP_REGS; i++) begin
            setup_ff[i] <= '0;
         end
         root_ff <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_TASK1_SETUP: setup_ff[0] <= csr_wr_data;
            CSR_TASK2_SETUP: setup_ff[1] <= csr_wr_data;
            CSR_TASK3_SETUP: setup_ff[2] <= csr_wr_data;
            CSR_TASK4_SETUP: setup_ff[3] <= csr_wr_data;
            CSR_ROOT_ENTRY:  root_ff <= csr_wr_data[ADDR_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      for (int i = 0; i < TASK_COUNT; i++) begin
         if (i == 0) begin
            setups[i] = '{autostart: 1'b0, prio: '0, start_addr: root_ff};
         end else if (i <= SETUP_REGS) begin
            setups[i] = task_setup_type'(setup_ff[i-1]);
         end else begin
            setups[i] = '0;
         end
      end
   end

endmodule

@@ hw/rtl/fpts_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpts_datapath
// Task table, scan registers and result register, driven one control word
// per cycle while exec is high.
// ----------------------------------------------------------------------------
module fpts_datapath (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_take,
   input  fpts_pkg::req_type           req_payload,
   input  logic                        exec,
   input  fpts_pkg::uword_type         uword,
   input  fpts_pkg::task_setup_type    setups [fpts_pkg::TASK_COUNT],
   output fpts_pkg::dp_status_type     status,
   output fpts_pkg::rsp_type           rsp_payload
);
   import fpts_pkg::*;

   task_state_type        state_ff [TASK_COUNT];
   logic [ADDR_BITS-1:0]  rp_ff [TASK_COUNT];
   task_idx_type          cur_ff;
   task_idx_type          scan_ff;
   task_idx_type          pick_ff;
   logic [PRIO_BITS-1:0]  best_ff;
   logic [TID_BITS-1:0]   tid_ff;
   logic [ADDR_BITS-1:0]  ret_ff;
   rsp_type               rsp_ff;

   task_idx_type          idx;
   logic                  idx_ok;
   logic                  tid_ok;
   task_state_type        rd_state;
   logic [ADDR_BITS-1:0]  rd_rp;
   task_setup_type        rd_setup;
   logic                  eligible;
   logic                  st_go;
   logic                  rp_go;
   logic [ADDR_BITS-1:0]  rp_val;
   task_state_type        st_val;

   function automatic logic cond_ok(input cond_type c, input task_state_type s,
                                    input logic autostart, input logic not_root,
                                    input logic tok);
      logic r;
      case (c)
         C_ALWAYS:      r = 1'b1;
         C_SUSP:        r = (s == TS_SUSPENDED);
         C_SUSP_AUTO:   r = (s == TS_SUSPENDED) && autostart;
         C_NOT_ROOT:    r = not_root;
         C_TID_OK:      r = tok;
         C_TID_OK_SUSP: r = tok && (s == TS_SUSPENDED);
         default:       r = 1'b0;
      endcase
      return r;
   endfunction

   always_comb begin
      case (uword.sel)
         SEL_ZERO: idx = '0;
         SEL_CUR:  idx = cur_ff;
         SEL_TID:  idx = TASK_BITS'(tid_ff);
         SEL_SCAN: idx = scan_ff;
         default:  idx = '0;
      endcase
      idx_ok   = (32'(idx) < 32'(TASK_COUNT));
      tid_ok   = (32'(tid_ff) < 32'(TASK_COUNT));
      rd_state = idx_ok ? state_ff[idx] : TS_SUSPENDED;
      rd_rp    = idx_ok ? rp_ff[idx] : '0;
      rd_setup = idx_ok ? setups[idx] : '0;
      eligible = (rd_state == TS_READY) || (rd_state == TS_RUNNING);
      st_go    = exec && idx_ok && (uword.st_wr != STW_NONE) &&
                 cond_ok(uword.st_cond, rd_state, rd_setup.autostart,
                         cur_ff != '0, tid_ok);
      rp_go    = exec && idx_ok && (uword.rp_wr != RPW_NONE) &&
                 cond_ok(uword.rp_cond, rd_state, rd_setup.autostart,
                         cur_ff != '0, tid_ok);
      rp_val   = (uword.rp_wr == RPW_RET) ? ret_ff : rd_setup.start_addr;
      case (uword.st_wr)
         STW_READY: st_val = TS_READY;
         STW_RUN:   st_val = TS_RUNNING;
         default:   st_val = TS_SUSPENDED;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TASK_COUNT; i++) begin
            state_ff[i] <= TS_SUSPENDED;
            rp_ff[i]    <= '0;
         end
         cur_ff  <= '0;
         scan_ff <= '0;
      end else begin
         if (st_go) begin
            state_ff[idx] <= st_val;
         end
         if (rp_go) begin
            rp_ff[idx] <= rp_val;
         end
         if (exec) begin
            case (uword.scan_op)
               SC_INIT_ZERO: scan_ff <= '0;
               SC_INIT_ONE:  scan_ff <= TASK_BITS'(1);
               SC_INC:       scan_ff <= scan_ff + TASK_BITS'(1);
               SC_PICK:      scan_ff <= scan_ff + TASK_BITS'(1);
               default: ;
            endcase
            case (uword.cur_op)
               CU_TID:  cur_ff <= TASK_BITS'(tid_ff);
               CU_PICK: cur_ff <= pick_ff;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         tid_ff <= req_payload.task_id;
         ret_ff <= req_payload.resume_address;
      end
      if (exec && (uword.scan_op == SC_INIT_ZERO)) begin
         best_ff <= '0;
         pick_ff <= '0;
      end else if (exec && (uword.scan_op == SC_PICK) && eligible &&
                   (rd_setup.prio >= best_ff)) begin
         best_ff <= rd_setup.prio;
         pick_ff <= scan_ff;
      end
      if (exec && uword.emit) begin
         rsp_ff.run_task     <= TID_BITS'(cur_ff);
         rsp_ff.jump_address <= rd_rp;
      end
   end

   assign status.scan_last = (scan_ff == TASK_BITS'(TASK_COUNT - 1));
   assign status.tid_bad   = !tid_ok;
   assign rsp_payload      = rsp_ff;

endmodule

@@ hw/rtl/fpts_seq.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpts_seq
// Step counter and control store: dispatch on the service call, conditional
// jumps, and the handshakes of both channels.
// ----------------------------------------------------------------------------
module fpts_seq (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  fpts_pkg::mode_type       req_mode,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   input  fpts_pkg::dp_status_type  status,
   output logic                     req_take,
   output logic                     exec,
   output fpts_pkg::uword_type      uword
);
   import fpts_pkg::*;

   logic     busy_ff, busy_in;
   step_type step_ff, step_in;
   logic     rsp_valid_ff, rsp_valid_in;
   logic     out_free;

   always_comb begin
      uword    = ucode_rom(step_ff);
      out_free = !rsp_valid_ff || rsp_ready;
      exec     = busy_ff && (!uword.emit || out_free);
      req_take = req_valid && !busy_ff;
      busy_in  = busy_ff;
      step_in  = step_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (req_take) begin
         busy_in = 1'b1;
         step_in = entry_of(req_mode);
      end else if (exec) begin
         case (uword.jump)
            J_NEXT:    step_in = step_ff + STEP_BITS'(1);
            J_GO:      step_in = uword.target;
            J_LOOP:    step_in = status.scan_last ? uword.target : step_ff;
            J_TID_BAD: step_in = status.tid_bad ? uword.target
                                                : step_ff + STEP_BITS'(1);
            default:   step_in = uword.target;
         endcase
         if (uword.emit) begin
            busy_in      = 1'b0;
            rsp_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         step_ff      <= STEP_START;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = !busy_ff;
   assign rsp_valid = rsp_valid_ff;

endmodule

@@ hw/rtl/fixed_priority_task_scheduler.sv @@
`timescale 1ns / 1ps
// path from request transaction to response valid, set by the microprogram
// and its scan loop over the task table (start scans first for autostart tasks):
//   chain leave, enter, out (leave, out on bad target); rest sched, scan, pick, out
// one call in flight: a new request is taken the cycle after the response is loaded
// synchronous active-high reset: all tasks suspended, resume addresses and current
// task zero, setup registers zero
// ----------------------------------------------------------------------------
// fixed_priority_task_scheduler
// Five-entry fixed-priority task table serving start, activate, chain and
// terminate calls with the task to run and its jump address.
// ----------------------------------------------------------------------------
module fixed_priority_task_scheduler (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  fpts_pkg::req_type                   req_payload,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output fpts_pkg::rsp_type                   rsp_payload,
   input  logic                                csr_wr_en,
   input  logic [fpts_pkg::CSR_IDX_BITS-1:0]   csr_index,
   input  logic [fpts_pkg::CSR_BITS-1:0]       csr_wr_data
);
   import fpts_pkg::*;

   task_setup_type setups [TASK_COUNT];
   dp_status_type  status;
   uword_type      uword;
   logic           req_take;
   logic           exec;

   fpts_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .setups      (setups)
   );

   fpts_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_mode  (req_payload.mode),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .req_take  (req_take),
      .exec      (exec),
      .uword     (uword)
   );

   fpts_datapath u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_take    (req_take),
      .req_payload (req_payload),
      .exec        (exec),
      .uword       (uword),
      .setups      (setups),
      .status      (status),
      .rsp_payload (rsp_payload)
   );

endmodule
